@@ hw/rtl/cfp_pkg.sv @@
// Shared types, constants and the CRC byte update for the CRC-16 frame parser.
package cfp_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 244;
  localparam int unsigned HEADER_BYTES        = 18;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;
  localparam int unsigned CFG_IDX_W           = 8;
  localparam int unsigned CFG_DATA_W          = 8;

  localparam logic [7:0]  MAGIC0   = 8'hF1;
  localparam logic [7:0]  MAGIC1   = 8'h58;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // header byte offsets
  localparam logic [7:0] OFF_MAGIC0     = 8'd0;
  localparam logic [7:0] OFF_MAGIC1     = 8'd1;
  localparam logic [7:0] OFF_VERSION    = 8'd2;
  localparam logic [7:0] OFF_TYPE       = 8'd3;
  localparam logic [7:0] OFF_SESSION_LO = 8'd4;
  localparam logic [7:0] OFF_SESSION_HI = 8'd5;
  localparam logic [7:0] OFF_PACKET_LO  = 8'd6;
  localparam logic [7:0] OFF_PACKET_HI  = 8'd7;
  localparam logic [7:0] OFF_FRAG       = 8'd8;
  localparam logic [7:0] OFF_FRAG_TOTAL = 8'd9;
  localparam logic [7:0] OFF_LEN_LO     = 8'd10;
  localparam logic [7:0] OFF_LEN_HI     = 8'd11;
  localparam logic [7:0] OFF_CNT_B0     = 8'd12;
  localparam logic [7:0] OFF_CNT_B1     = 8'd13;
  localparam logic [7:0] OFF_CNT_B2     = 8'd14;
  localparam logic [7:0] OFF_CNT_B3     = 8'd15;
  localparam logic [7:0] OFF_CRC_LO     = 8'd16;
  localparam logic [7:0] OFF_CRC_HI     = 8'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VERSION   = 8'd0,
    CFG_MAX_VERSION   = 8'd1,
    CFG_MAX_PAYLOAD   = 8'd2,
    CFG_MAX_FRAGMENTS = 8'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_LENGTH   = 3'd2,
    ST_MAGIC    = 3'd3,
    ST_FRAGMENT = 3'd4,
    ST_CRC      = 3'd5,
    ST_VERSION  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        is_payload;
    logic        frame_done;
    logic [2:0]  status;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [15:0] session_id;
    logic [15:0] packet_id;
    logic [7:0]  fragment_index;
    logic [7:0]  fragment_total;
    logic [7:0]  payload_len;
    logic [31:0] sequence_counter;
  } out_word_t;

  typedef struct packed {
    logic [7:0] min_version;
    logic [7:0] max_version;
    logic [7:0] max_payload;
    logic [5:0] max_fragments;
  } cfg_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [7:0] pos;
    logic       short_err;
    logic       len_err;
  } mid_word_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/cfp_fifo.sv @@
// Small register queue with fall-through head, used on both sides of the parser.
module cfp_fifo #(
  parameter type         T     = logic [7:0],
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T                slots_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [AW:0]     count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ hw/rtl/cfp_front.sv @@
// Front end: counts byte offsets and flags frame length errors per byte.
module cfp_front #(
  parameter int unsigned MAX_FRAME_BYTES = cfp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  cfp_pkg::in_word_t  in_word_i,
  output cfp_pkg::mid_word_t mid_word_o
);
  import cfp_pkg::*;

  logic [7:0] byte_index_q, byte_index_d;
  logic       overlong_q, overlong_d;
  logic [8:0] n;
  logic       sat;

  assign n   = {1'b0, byte_index_q} + 9'd1;
  assign sat = (byte_index_q == 8'hFF);

  always_comb begin
    overlong_d   = overlong_q | sat;
    byte_index_d = sat ? byte_index_q : n[7:0];
    mid_word_o.data      = in_word_i.data_byte;
    mid_word_o.last      = in_word_i.last_byte;
    mid_word_o.pos       = byte_index_q;
    mid_word_o.short_err = (n < 9'(HEADER_BYTES));
    mid_word_o.len_err   = overlong_d || (n > 9'(MAX_FRAME_BYTES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      overlong_q   <= 1'b0;
    end else if (take_i) begin
      if (in_word_i.last_byte) begin
        byte_index_q <= '0;
        overlong_q   <= 1'b0;
      end else begin
        byte_index_q <= byte_index_d;
        overlong_q   <= overlong_d;
      end
    end
  end

endmodule

@@ hw/rtl/cfp_back.sv @@
// Back end: header capture, CRC accumulation and the end-of-frame status.
module cfp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  cfp_pkg::mid_word_t mid_word_i,
  input  cfp_pkg::cfg_t      cfg_i,
  output cfp_pkg::out_word_t out_word_o
);
  import cfp_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_want_q, crc_want_d;
  logic        magic_bad_q, magic_bad_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] session_q, session_d;
  logic [15:0] packet_q, packet_d;
  logic [7:0]  frag_q, frag_d;
  logic [7:0]  frag_total_q, frag_total_d;
  logic [15:0] len_q, len_d;
  logic [31:0] counter_q, counter_d;
  logic [8:0]  n;
  logic        hdr_byte;
  logic        crc_byte_en;
  status_e     status;

  assign n           = {1'b0, mid_word_i.pos} + 9'd1;
  assign hdr_byte    = (mid_word_i.pos < 8'(HEADER_BYTES));
  assign crc_byte_en = (mid_word_i.pos < OFF_CRC_LO) || !hdr_byte;

  // next frame state with this byte folded in
  always_comb begin
    crc_d        = crc_byte_en ? crc16_byte(crc_q, mid_word_i.data) : crc_q;
    crc_want_d   = crc_want_q;
    magic_bad_d  = magic_bad_q;
    version_d    = version_q;
    type_d       = type_q;
    session_d    = session_q;
    packet_d     = packet_q;
    frag_d       = frag_q;
    frag_total_d = frag_total_q;
    len_d        = len_q;
    counter_d    = counter_q;
    unique case (mid_word_i.pos)
      OFF_MAGIC0:     magic_bad_d = magic_bad_q | (mid_word_i.data != MAGIC0);
      OFF_MAGIC1:     magic_bad_d = magic_bad_q | (mid_word_i.data != MAGIC1);
      OFF_VERSION:    version_d = mid_word_i.data;
      OFF_TYPE:       type_d = mid_word_i.data;
      OFF_SESSION_LO: session_d[7:0] = mid_word_i.data;
      OFF_SESSION_HI: session_d[15:8] = mid_word_i.data;
      OFF_PACKET_LO:  packet_d[7:0] = mid_word_i.data;
      OFF_PACKET_HI:  packet_d[15:8] = mid_word_i.data;
      OFF_FRAG:       frag_d = mid_word_i.data;
      OFF_FRAG_TOTAL: frag_total_d = mid_word_i.data;
      OFF_LEN_LO:     len_d[7:0] = mid_word_i.data;
      OFF_LEN_HI:     len_d[15:8] = mid_word_i.data;
      OFF_CNT_B0:     counter_d[7:0] = mid_word_i.data;
      OFF_CNT_B1:     counter_d[15:8] = mid_word_i.data;
      OFF_CNT_B2:     counter_d[23:16] = mid_word_i.data;
      OFF_CNT_B3:     counter_d[31:24] = mid_word_i.data;
      OFF_CRC_LO:     crc_want_d[7:0] = mid_word_i.data;
      OFF_CRC_HI:     crc_want_d[15:8] = mid_word_i.data;
      default: ;
    endcase
  end

  // priority order of the checks matters
  always_comb begin
    if (mid_word_i.short_err) begin
      status = ST_SHORT;
    end else if (mid_word_i.len_err) begin
      status = ST_LENGTH;
    end else if (magic_bad_d) begin
      status = ST_MAGIC;
    end else if ((17'(len_d) + 17'(HEADER_BYTES)) != 17'(n)) begin
      status = ST_LENGTH;
    end else if (len_d > {8'h00, cfg_i.max_payload}) begin
      status = ST_LENGTH;
    end else if ((frag_total_d == 8'h00) || (frag_total_d > {2'b00, cfg_i.max_fragments})
                 || (frag_d >= frag_total_d)) begin
      status = ST_FRAGMENT;
    end else if (crc_d != crc_want_d) begin
      status = ST_CRC;
    end else if ((version_d < cfg_i.min_version) || (version_d > cfg_i.max_version)) begin
      status = ST_VERSION;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    out_word_o                  = '0;
    out_word_o.echo_byte        = mid_word_i.data;
    out_word_o.is_payload       = !hdr_byte;
    out_word_o.frame_done       = mid_word_i.last;
    if (mid_word_i.last) begin
      out_word_o.status = status;
      if (status == ST_OK) begin
        out_word_o.version          = version_d;
        out_word_o.msg_type         = type_d;
        out_word_o.session_id       = session_d;
        out_word_o.packet_id        = packet_d;
        out_word_o.fragment_index   = frag_d;
        out_word_o.fragment_total   = frag_total_d;
        out_word_o.payload_len      = len_d[7:0];
        out_word_o.sequence_counter = counter_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= CRC_INIT;
      crc_want_q   <= '0;
      magic_bad_q  <= 1'b0;
      version_q    <= '0;
      type_q       <= '0;
      session_q    <= '0;
      packet_q     <= '0;
      frag_q       <= '0;
      frag_total_q <= '0;
      len_q        <= '0;
      counter_q    <= '0;
    end else if (take_i) begin
      if (mid_word_i.last) begin
        crc_q        <= CRC_INIT;
        crc_want_q   <= '0;
        magic_bad_q  <= 1'b0;
        version_q    <= '0;
        type_q       <= '0;
        session_q    <= '0;
        packet_q     <= '0;
        frag_q       <= '0;
        frag_total_q <= '0;
        len_q        <= '0;
        counter_q    <= '0;
      end else begin
        crc_q        <= crc_d;
        crc_want_q   <= crc_want_d;
        magic_bad_q  <= magic_bad_d;
        version_q    <= version_d;
        type_q       <= type_d;
        session_q    <= session_d;
        packet_q     <= packet_d;
        frag_q       <= frag_d;
        frag_total_q <= frag_total_d;
        len_q        <= len_d;
        counter_q    <= counter_d;
      end
    end
  end

endmodule

@@ hw/rtl/crc16_frame_parser_core.sv @@
// Top level of the CRC-16 frame parser: front end, queues, back end and config registers.
//
// Frame bytes enter through a queue-style port: a word is taken when push is high
// and full is low. Each byte gives one result word, read from a queue-style port:
// the oldest result shows while empty is low and leaves when pop is high.
// Every byte is echoed with a payload flag; the word of the byte marked last also
// carries the frame status and, when the frame is good, the decoded header.
// One byte per cycle is sustained while pop stays high; a byte's result becomes visible
// once it is taken into the byte queue and then by the back end into the result queue.
// The back end's CRC byte update and status checks are combinational between the two
// queues.
// When pop stays low the result queue fills, the back end holds, then the byte
// queue fills and full rises; nothing is dropped.
// Config writes (cfg_valid_i, index, data) are always accepted; an index beyond
// the four registers is ignored. Write them only while no frame is in flight.
// Reset empties both queues, clears the frame state and loads the register
// defaults: min/max version 1, max payload 226, max fragments 32.
module crc16_frame_parser_core #(
  parameter int unsigned MAX_FRAME_BYTES = cfp_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH     = cfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  cfp_pkg::in_word_t                in_word_i,
  output logic                             empty,
  input  logic                             pop,
  output cfp_pkg::out_word_t               out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cfp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cfp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cfp_pkg::*;

  cfg_t      cfg_q, cfg_d;
  mid_word_t front_word;
  mid_word_t mid_head;
  out_word_t back_word;
  logic      in_take;
  logic      mid_empty;
  logic      res_full;
  logic      back_take;

  assign cfg_ready_o = 1'b1;
  assign in_take     = push && !full;
  assign back_take   = !mid_empty && !res_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_VERSION:   cfg_d.min_version   = cfg_data_i[7:0];
        CFG_MAX_VERSION:   cfg_d.max_version   = cfg_data_i[7:0];
        CFG_MAX_PAYLOAD:   cfg_d.max_payload   = cfg_data_i[7:0];
        CFG_MAX_FRAGMENTS: cfg_d.max_fragments = cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_version   <= 8'd1;
      cfg_q.max_version   <= 8'd1;
      cfg_q.max_payload   <= 8'd226;
      cfg_q.max_fragments <= 6'd32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cfp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (in_take),
    .in_word_i (in_word_i),
    .mid_word_o(front_word)
  );

  cfp_fifo #(
    .T    (mid_word_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(front_word),
    .full_o (full),
    .pop_i  (back_take),
    .rdata_o(mid_head),
    .empty_o(mid_empty)
  );

  cfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (back_take),
    .mid_word_i(mid_head),
    .cfg_i     (cfg_q),
    .out_word_o(back_word)
  );

  cfp_fifo #(
    .T    (out_word_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_take),
    .wdata_i(back_word),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(out_word_o),
    .empty_o(empty)
  );

endmodule

@@ tb/tb_crc16_frame_parser_core.sv @@
// Self-checking testbench for the CRC-16 frame parser core: directed and random frames.
module tb_crc16_frame_parser_core;
  import cfp_pkg::*;

  localparam int unsigned RANDOM_BYTES  = 300;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned STALL_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned IDLE_PCT      = 9;
  localparam int unsigned TIMEOUT_UNITS = 4_000_000;
  localparam int unsigned FRAME_LIMIT   = MAX_FRAME_BYTES_DEF;

  // indexes past the register list, writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } reg_write_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  in_word_t              in_word_i;
  logic                  empty;
  logic                  pop;
  out_word_t             out_word_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  crc16_frame_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_word_i   (in_word_i),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // register copies
  logic [7:0]  shadow_min;
  logic [7:0]  shadow_max;
  logic [7:0]  shadow_max_pay;
  logic [5:0]  shadow_max_frag;

  // frame state of the parser
  logic [7:0]  pos_cnt;
  logic        too_long;
  logic        magic_err;
  logic [15:0] crc_run;
  logic [15:0] crc_hdr;
  logic [7:0]  f_version;
  logic [7:0]  f_type;
  logic [15:0] f_session;
  logic [15:0] f_packet;
  logic [7:0]  f_frag;
  logic [7:0]  f_total;
  logic [15:0] f_len;
  logic [31:0] f_counter;

  out_word_t   pending_results[$];
  logic [7:0]  frame_bytes[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int          hold_off   = 0;
  bit          calm       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic void clear_frame();
    pos_cnt   = '0;
    too_long  = 1'b0;
    magic_err = 1'b0;
    crc_run   = CRC_INIT;
    crc_hdr   = '0;
    f_version = '0;
    f_type    = '0;
    f_session = '0;
    f_packet  = '0;
    f_frag    = '0;
    f_total   = '0;
    f_len     = '0;
    f_counter = '0;
  endfunction

  // advance the frame state by one byte and return the word it produces
  function automatic out_word_t parse_byte(input logic [7:0] b, input logic eof);
    out_word_t   w;
    int unsigned n;
    status_e     st;
    w            = '0;
    n            = 32'(pos_cnt) + 1;
    w.echo_byte  = b;
    w.is_payload = (pos_cnt >= HEADER_BYTES);
    w.frame_done = eof;
    case (pos_cnt)
      OFF_MAGIC0:     if (b != MAGIC0) magic_err = 1'b1;
      OFF_MAGIC1:     if (b != MAGIC1) magic_err = 1'b1;
      OFF_VERSION:    f_version = b;
      OFF_TYPE:       f_type = b;
      OFF_SESSION_LO: f_session[7:0] = b;
      OFF_SESSION_HI: f_session[15:8] = b;
      OFF_PACKET_LO:  f_packet[7:0] = b;
      OFF_PACKET_HI:  f_packet[15:8] = b;
      OFF_FRAG:       f_frag = b;
      OFF_FRAG_TOTAL: f_total = b;
      OFF_LEN_LO:     f_len[7:0] = b;
      OFF_LEN_HI:     f_len[15:8] = b;
      OFF_CNT_B0:     f_counter[7:0] = b;
      OFF_CNT_B1:     f_counter[15:8] = b;
      OFF_CNT_B2:     f_counter[23:16] = b;
      OFF_CNT_B3:     f_counter[31:24] = b;
      OFF_CRC_LO:     crc_hdr[7:0] = b;
      OFF_CRC_HI:     crc_hdr[15:8] = b;
      default: ;
    endcase
    // the CRC field itself is skipped
    if (pos_cnt != OFF_CRC_LO && pos_cnt != OFF_CRC_HI) crc_run = crc_step(crc_run, b);
    if (n > 255) begin
      too_long = 1'b1;
      pos_cnt  = 8'hFF;
    end else begin
      pos_cnt = 8'(n);
    end
    if (eof) begin
      if (n < HEADER_BYTES) st = ST_SHORT;
      else if (too_long || n > FRAME_LIMIT) st = ST_LENGTH;
      else if (magic_err) st = ST_MAGIC;
      else if (32'(f_len) + HEADER_BYTES != n) st = ST_LENGTH;
      else if (f_len > 16'(shadow_max_pay)) st = ST_LENGTH;
      else if (f_total == 0 || f_total > 8'(shadow_max_frag) || f_frag >= f_total)
        st = ST_FRAGMENT;
      else if (crc_run != crc_hdr) st = ST_CRC;
      else if (f_version < shadow_min || f_version > shadow_max) st = ST_VERSION;
      else st = ST_OK;
      w.status = st;
      if (st == ST_OK) begin
        w.version          = f_version;
        w.msg_type         = f_type;
        w.session_id       = f_session;
        w.packet_id        = f_packet;
        w.fragment_index   = f_frag;
        w.fragment_total   = f_total;
        w.payload_len      = f_len[7:0];
        w.sequence_counter = f_counter;
      end
      clear_frame();
    end
    return w;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= in_word_t'{b, eof};
    do @(posedge clk_i); while (full);
    pending_results.push_back(parse_byte(b, eof));
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[k]) send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] minv, input logic [7:0] maxv,
                              input logic [7:0] maxp, input logic [7:0] maxf,
                              input bit with_stray);
    reg_write_t wr[$];
    wr.push_back(reg_write_t'{CFG_MIN_VERSION, minv});
    wr.push_back(reg_write_t'{CFG_MAX_VERSION, maxv});
    wr.push_back(reg_write_t'{CFG_MAX_PAYLOAD, maxp});
    wr.push_back(reg_write_t'{CFG_MAX_FRAGMENTS, maxf});
    if (with_stray) begin
      wr.push_back(reg_write_t'{CFG_IDX_SPARE, 8'($urandom)});
      wr.push_back(reg_write_t'{CFG_IDX_TOP, 8'($urandom)});
    end
    wait_idle();
    foreach (wr[k]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= wr[k].idx;
      cfg_data_i  <= wr[k].val;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (wr[k].idx)
        CFG_MIN_VERSION:   shadow_min = wr[k].val;
        CFG_MAX_VERSION:   shadow_max = wr[k].val;
        CFG_MAX_PAYLOAD:   shadow_max_pay = wr[k].val;
        CFG_MAX_FRAGMENTS: shadow_max_frag = wr[k].val[5:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic seal_crc(input bit crc_ok);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_bytes[k])
      if (k != OFF_CRC_LO && k != OFF_CRC_HI) c = crc_step(c, frame_bytes[k]);
    if (!crc_ok) c ^= 16'(1 << $urandom_range(15));
    frame_bytes[OFF_CRC_LO] = c[7:0];
    frame_bytes[OFF_CRC_HI] = c[15:8];
  endtask

  task automatic build_frame(input logic [7:0] ver, input logic [7:0] typ,
                             input logic [15:0] sess, input logic [15:0] pkt,
                             input logic [7:0] frag, input logic [7:0] total,
                             input logic [15:0] decl_len, input logic [31:0] cnt,
                             input int unsigned pay_n, input bit crc_ok);
    frame_bytes = {MAGIC0, MAGIC1, ver, typ, sess[7:0], sess[15:8], pkt[7:0], pkt[15:8],
                   frag, total, decl_len[7:0], decl_len[15:8], cnt[7:0], cnt[15:8],
                   cnt[23:16], cnt[31:24], 8'h00, 8'h00};
    repeat (pay_n) frame_bytes.push_back(8'($urandom_range(255)));
    seal_crc(crc_ok);
  endtask

  // well-formed frame; accepted when the version window and fragment limit are non-empty and pay_n fits
  task automatic build_good(input int unsigned pay_n);
    logic [7:0] ver;
    logic [7:0] total;
    if (shadow_min <= shadow_max) ver = shadow_min + 8'($urandom_range(shadow_max - shadow_min));
    else ver = 8'($urandom_range(255));
    if (shadow_max_frag != 0) total = 8'($urandom_range(shadow_max_frag, 1));
    else total = 8'($urandom_range(255, 1));
    build_frame(ver, 8'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom_range(total - 1)), total, 16'(pay_n), $urandom, pay_n, 1'b1);
  endtask

  function automatic int unsigned pick_payload();
    int unsigned n;
    n = ($urandom_range(99) < 5) ? $urandom_range(226) : $urandom_range(24);
    if (n > shadow_max_pay) n = shadow_max_pay;
    return n;
  endfunction

  task automatic random_frame();
    int unsigned pay;
    int unsigned k;
    pay = pick_payload();
    if ($urandom_range(99) < 70) begin
      build_good(pay);
    end else begin
      case ($urandom_range(8))
        0: begin
          build_good(pay);
          k = $urandom_range(frame_bytes.size() - 1);
          frame_bytes[k] ^= 8'(1 << $urandom_range(7));
        end
        1: begin
          build_good(pay);
          repeat ($urandom_range(frame_bytes.size() - 1, 1)) void'(frame_bytes.pop_back());
        end
        2: begin
          build_good(pay);
          repeat ($urandom_range(8, 1)) frame_bytes.push_back(8'($urandom_range(255)));
        end
        3: begin
          build_good(pay);
          frame_bytes[OFF_LEN_HI] = 8'($urandom_range(255, 1));
          seal_crc(1'b1);
        end
        4: begin
          build_good(pay);
          if ($urandom_range(1)) frame_bytes[OFF_FRAG_TOTAL] = 8'h00;
          else frame_bytes[OFF_FRAG] = frame_bytes[OFF_FRAG_TOTAL]
                                       + 8'($urandom_range(255 - frame_bytes[OFF_FRAG_TOTAL]));
          seal_crc(1'b1);
        end
        5: begin
          build_good(pay);
          seal_crc(1'b0);
        end
        6: begin
          build_good(pay);
          frame_bytes[OFF_VERSION] = 8'($urandom_range(255));
          seal_crc(1'b1);
        end
        7: begin
          frame_bytes = {};
          repeat ($urandom_range(40, 1)) frame_bytes.push_back(8'($urandom_range(255)));
          if (frame_bytes.size() >= 2 && $urandom_range(1)) begin
            frame_bytes[OFF_MAGIC0] = MAGIC0;
            frame_bytes[OFF_MAGIC1] = MAGIC1;
          end
        end
        default: build_good(32'(shadow_max_pay) + 1);
      endcase
    end
  endtask

  task automatic test_defaults();
    build_good(0);
    send_frame();
    build_good(7);
    send_frame();
    build_frame(8'd1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd31, 8'd32, 16'd0, 32'hFFFF_FFFF, 0, 1'b1);
    send_frame();
    // version just under and just over the default window
    build_frame(8'd0, 8'h00, 16'h0000, 16'h0000, 8'd0, 8'd1, 16'd0, 32'h0, 0, 1'b1);
    send_frame();
    build_frame(8'd2, 8'hFF, 16'hFFFF, 16'hFFFF, 8'd0, 8'd1, 16'd1, 32'hFFFF_FFFF, 1, 1'b1);
    send_frame();
  endtask

  task automatic test_framing_errors();
    // long frames go through with no idling on either side
    calm = 1'b1;
    frame_bytes = {MAGIC0};
    send_frame();
    build_good(0);
    void'(frame_bytes.pop_back());
    send_frame();
    // declared length disagrees with the bytes seen
    build_good(3);
    frame_bytes[OFF_LEN_LO] = 8'd4;
    send_frame();
    build_good(0);
    frame_bytes[OFF_LEN_HI] = 8'h01;
    send_frame();
    // longest legal frame, then one byte past it
    build_good(226);
    send_frame();
    build_good(227);
    send_frame();
    // byte count at its top: 255 bytes, then an overlong frame that saturates it
    build_good(237);
    send_frame();
    build_good(242);
    send_frame();
    calm = 1'b0;
  endtask

  task automatic test_header_checks();
    build_good(2);
    frame_bytes[OFF_MAGIC0] = 8'h00;
    send_frame();
    build_good(2);
    frame_bytes[OFF_MAGIC1] = 8'hFF;
    send_frame();
    build_frame(8'd1, 8'h10, 16'h1234, 16'h5678, 8'd0, 8'd0, 16'd0, 32'h1, 0, 1'b1);
    send_frame();
    build_frame(8'd1, 8'h10, 16'h1234, 16'h5678, 8'd5, 8'd5, 16'd0, 32'h1, 0, 1'b1);
    send_frame();
    build_frame(8'd1, 8'h10, 16'h1234, 16'h5678, 8'd0, 8'd33, 16'd0, 32'h1, 0, 1'b1);
    send_frame();
    build_frame(8'd1, 8'h22, 16'hA5A5, 16'h5A5A, 8'd0, 8'd1, 16'd5, 32'h8000_0001, 5, 1'b0);
    send_frame();
  endtask

  task automatic test_register_extremes();
    program_regs(8'd0, 8'd255, 8'd0, 8'd1, 1'b1);
    build_frame(8'hFF, 8'h01, 16'h0001, 16'h0001, 8'd0, 8'd1, 16'd0, 32'h2, 0, 1'b1);
    send_frame();
    build_frame(8'h00, 8'h01, 16'h0001, 16'h0001, 8'd0, 8'd1, 16'd0, 32'h2, 0, 1'b1);
    send_frame();
    build_good(1);
    send_frame();
    build_frame(8'd7, 8'h01, 16'h0001, 16'h0001, 8'd0, 8'd2, 16'd0, 32'h2, 0, 1'b1);
    send_frame();
    // zero fragment limit turns every otherwise well-formed frame into a fragment error
    program_regs(8'd255, 8'd255, 8'd226, 8'd0, 1'b0);
    build_good(4);
    send_frame();
    // upper data bits are dropped, limit becomes 63; empty version window
    program_regs(8'd9, 8'd3, 8'd100, 8'hFF, 1'b0);
    build_frame(8'd5, 8'h01, 16'h0001, 16'h0001, 8'd62, 8'd63, 16'd0, 32'h2, 0, 1'b1);
    send_frame();
    build_good(100);
    send_frame();
  endtask

  task automatic test_backpressure();
    program_regs(8'd1, 8'd1, 8'd226, 8'd32, 1'b0);
    hold_off = STALL_CYCLES;
    repeat (4) begin
      build_good($urandom_range(30, 10));
      send_frame();
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned goal;
    logic [7:0]  minv;
    logic [7:0]  maxv;
    start = bytes_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(8'd1, 8'd1, 8'd226, 8'd32, 1'b0);
        1: program_regs(8'd0, 8'd255, 8'd226, 8'd32, 1'b0);
        2: program_regs(8'd5, 8'd9, 8'd40, 8'd4, 1'b0);
        default: begin
          minv = 8'($urandom_range(255));
          if ($urandom_range(99) < 80) maxv = minv + 8'($urandom_range(255 - minv));
          else maxv = 8'($urandom_range(255));
          program_regs(minv, maxv, 8'($urandom_range(226)), 8'($urandom_range(255)),
                       ph == PHASES - 1);
        end
      endcase
      calm = (ph == 1);
      goal = start + (ph + 1) * RANDOM_BYTES / PHASES;
      while (bytes_sent < goal) begin
        random_frame();
        send_frame();
      end
    end
    wait_idle();
    calm = 1'b0;
  endtask

  // result side: random pops, hold-off on request, compare against the oldest prediction
  initial begin : result_monitor
    out_word_t got;
    out_word_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = out_word_o;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word at %0t: %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got.echo_byte !== want.echo_byte || got.is_payload !== want.is_payload ||
              got.frame_done !== want.frame_done || got.status !== want.status ||
              got.version !== want.version || got.msg_type !== want.msg_type ||
              got.session_id !== want.session_id || got.packet_id !== want.packet_id ||
              got.fragment_index !== want.fragment_index ||
              got.fragment_total !== want.fragment_total ||
              got.payload_len !== want.payload_len ||
              got.sequence_counter !== want.sequence_counter) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch at %0t: byte %h/%h status %0d/%0d word exp %h got %h",
                       $time, want.echo_byte, got.echo_byte, want.status, got.status,
                       want, got);
          end
        end
      end
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    in_word_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    shadow_min      = 8'd1;
    shadow_max      = 8'd1;
    shadow_max_pay  = 8'd226;
    shadow_max_frag = 6'd32;
    clear_frame();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_defaults();
    test_framing_errors();
    test_header_checks();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_fifo.sv
hw/rtl/cfp_front.sv
hw/rtl/cfp_back.sv
hw/rtl/crc16_frame_parser_core.sv
tb/tb_crc16_frame_parser_core.sv
